@@ sv/med_predictive_residual_codec_core_macros.svh @@
// Assertion macros for the MED predictive residual codec.
`ifndef MED_PREDICTIVE_RESIDUAL_CODEC_CORE_MACROS_SVH
`define MED_PREDICTIVE_RESIDUAL_CODEC_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MPRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MPRC_ASSERT_NOW(lbl, ante, cons, msg)
`define MPRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/mprc_pkg.sv @@
// Shared types and constants of the MED predictive residual codec.
`default_nettype none
package mprc_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = COL_W + 1;
	localparam int HEIGHT_W  = 16;
	localparam int PIX_W     = 8;
	localparam int SAMPLE_W  = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(256);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DECODE_MODE  = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_idx_t;

	// left, upper and upper-left neighbours, already zeroed at the borders
	typedef struct packed {
		logic [PIX_W-1:0] a;
		logic [PIX_W-1:0] b;
		logic [PIX_W-1:0] c;
	} nbr_t;

endpackage
`default_nettype wire

@@ sv/mprc_ifs.sv @@
// Stream and configuration channel interfaces of the codec.
`default_nettype none
interface mprc_in_if import mprc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface mprc_out_if import mprc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       end_of_image;
	modport source (output valid, output sample_out, output end_of_image, input ready);
	modport sink (input valid, input sample_out, input end_of_image, output ready);
endinterface

interface mprc_cfg_if import mprc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/mprc_line_store.sv @@
// Previous-row line store: one write port, one registered read port.
`default_nettype none
module mprc_line_store import mprc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [COL_W-1:0] wr_addr,
	input  wire logic [PIX_W-1:0] wr_data,
	input  wire logic [COL_W-1:0] rd_addr,
	output logic      [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

@@ sv/mprc_pixel_calc.sv @@
// MED prediction plus encode/decode arithmetic for one pixel.
`default_nettype none
module mprc_pixel_calc import mprc_pkg::*; (
	input  wire  nbr_t                    nbr,
	input  wire  logic signed [SAMPLE_W-1:0] sample,
	input  wire  logic                    decode,
	output logic              [PIX_W-1:0] pixel,
	output logic signed [SAMPLE_W-1:0]    result
);

	logic [PIX_W-1:0]         hi, lo, pred;
	logic [PIX_W+1:0]         grad;
	logic signed [PIX_W+2:0]  sum;
	logic [PIX_W-1:0]         enc_pix;
	logic signed [SAMPLE_W:0] resid;

	always_comb begin
		hi   = (nbr.a > nbr.b) ? nbr.a : nbr.b;
		lo   = (nbr.a > nbr.b) ? nbr.b : nbr.a;
		grad = {2'b00, nbr.a} + {2'b00, nbr.b} - {2'b00, nbr.c};
		priority if (nbr.c >= hi) begin
			pred = lo;
		end else if (nbr.c <= lo) begin
			pred = hi;
		end else begin
			// c strictly between a and b keeps the gradient in 0..255
			pred = grad[PIX_W-1:0];
		end

		sum = $signed({3'b000, pred}) + (PIX_W+3)'(sample);
		enc_pix = sample[SAMPLE_W-1] ? '0 : sample[PIX_W-1:0];
		// both operands lie in 0..255, so the residual never leaves +-255
		resid = $signed({2'b00, enc_pix}) - $signed({2'b00, pred});

		if (decode) begin
			priority if (sum < 0) begin
				pixel = '0;
			end else if (sum > (PIX_W+3)'(255)) begin
				pixel = '1;
			end else begin
				pixel = sum[PIX_W-1:0];
			end
			result = $signed({1'b0, pixel});
		end else begin
			pixel  = enc_pix;
			result = resid[SAMPLE_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ sv/med_predictive_residual_codec_core.sv @@
// Top level of the MED predictive residual codec.
// Pixels (encode) or residuals (decode) enter in raster order, one beat per clock, and each gives
// one result beat via the s1 register and then the output register; the block keeps that rate while
// the sink takes beats. The previous row sits in a 4096 x 8 line store with one write and one
// registered read port: the entry for the next pixel is read as the current one is written, and a
// read of the entry being written that cycle (at width 1, or when s1 drains) is forwarded. The
// left-neighbour loop (prediction, add, clamp) is combinational, closing through left_q. The line
// store is not cleared after reset; rows above the first are always written before they are read.
// Configuration writes are taken at any time and must only happen while the block is idle.
`default_nettype none
`include "med_predictive_residual_codec_core_macros.svh"
module med_predictive_residual_codec_core import mprc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mprc_in_if.sink    samples,
	mprc_out_if.source results,
	mprc_cfg_if.sink   cfg
);

	logic                decode_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;

	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [PIX_W-1:0]    left_q, ul_q;

	logic                       s1_valid_q;
	logic [COL_W-1:0]           s1_x_s1;
	logic                       s1_xz_s1, s1_yz_s1, s1_eoi_s1;
	logic signed [SAMPLE_W-1:0] s1_sample_s1;

	logic                       out_valid_q, out_eoi_q, out_dec_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	logic                fwd_q;
	logic [PIX_W-1:0]    fwd_data_q;

	logic                in_fire, s1_adv, last_col, last_row;
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [COL_W-1:0]    rd_addr;
	logic [PIX_W-1:0]    rd_data, b_raw, pixel;
	logic signed [SAMPLE_W-1:0] result;
	nbr_t                nbr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_q <= 1'b0;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_DECODE_MODE:  decode_q <= cfg.data[0];
				CFG_IMAGE_WIDTH:  width_q  <= cfg.data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg.data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign s1_adv        = s1_valid_q && (!out_valid_q || results.ready);
	assign samples.ready = !s1_valid_q || s1_adv;
	assign in_fire       = samples.valid && samples.ready;

	always_comb begin
		priority if (width_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff    = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		last_col = ({1'b0, col_q} + WIDTH_W'(1)) >= w_eff;
		last_row = ({1'b0, row_q} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff};
	end

	// position counters advance at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + HEIGHT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (samples.ready) begin
			s1_valid_q <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_x_s1      <= col_q;
			s1_xz_s1     <= (col_q == '0);
			s1_yz_s1     <= (row_q == '0);
			s1_eoi_s1    <= last_col && last_row;
			s1_sample_s1 <= samples.sample_in;
		end
	end

	// held items re-read their own entry; no write lands while s1 holds
	assign rd_addr = in_fire ? col_q : s1_x_s1;

	mprc_line_store u_store (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (s1_x_s1),
		.wr_data (pixel),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= s1_adv && (s1_x_s1 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= pixel;
	end

	always_comb begin
		b_raw = fwd_q ? fwd_data_q : rd_data;
		nbr.a = s1_xz_s1 ? '0 : left_q;
		nbr.b = s1_yz_s1 ? '0 : b_raw;
		nbr.c = (s1_xz_s1 || s1_yz_s1) ? '0 : ul_q;
	end

	mprc_pixel_calc u_calc (
		.nbr    (nbr),
		.sample (s1_sample_s1),
		.decode (decode_q),
		.pixel  (pixel),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			ul_q   <= '0;
		end else if (s1_adv) begin
			left_q <= pixel;
			ul_q   <= nbr.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_sample_q <= result;
			out_eoi_q    <= s1_eoi_s1;
			out_dec_q    <= decode_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.sample_out   = out_sample_q;
	assign results.end_of_image = out_eoi_q;

	`MPRC_ASSERT_NEXT(a_eoi_wraps, in_fire && last_col && last_row, col_q == '0 && row_q == '0, "position did not wrap after the last pixel")
	`MPRC_ASSERT_NEXT(a_s1_to_out, s1_adv, out_valid_q, "advanced item missing from output register")
	`MPRC_ASSERT_NOW(a_dec_range, out_valid_q && out_dec_q, !out_sample_q[SAMPLE_W-1], "decoded pixel outside 0..255")
	`MPRC_ASSERT_NOW(a_enc_range, out_valid_q && !out_dec_q, out_sample_q != {1'b1, {(SAMPLE_W-1){1'b0}}}, "residual outside +-255")

endmodule
`default_nettype wire
